@@ design/cbs_pkg.sv @@
// Shared types, constants and box compare for the crop box stabilizer.
package cbs_pkg;

   localparam int DIM_BITS  = 13;
   localparam int SIZE_BITS = DIM_BITS + 1;
   localparam int TIME_BITS = 32;
   localparam int CNT_BITS  = 16;
   localparam int STEP_BITS = 12;
   localparam int CSR_BITS  = 3;
   localparam int DATA_BITS = 32;

   localparam logic [SIZE_BITS-1:0] SIZE_TOL      = SIZE_BITS'(8);
   localparam logic [DIM_BITS-1:0]  OFFSET_TOL    = DIM_BITS'(4);
   localparam logic [SIZE_BITS-1:0] LETTERBOX_PAD = SIZE_BITS'(2);
   localparam logic [CNT_BITS-1:0]  CNT_MAX       = '1;

   // Register indexes on the csr port.
   localparam logic [CSR_BITS-1:0] CSR_VOTE_FLOOR  = 3'd0;
   localparam logic [CSR_BITS-1:0] CSR_KEEP_EVERY  = 3'd1;
   localparam logic [CSR_BITS-1:0] CSR_REVERT_WIN  = 3'd2;
   localparam logic [CSR_BITS-1:0] CSR_START_VALID = 3'd3;
   localparam logic [CSR_BITS-1:0] CSR_START_W     = 3'd4;
   localparam logic [CSR_BITS-1:0] CSR_START_H     = 3'd5;
   localparam logic [CSR_BITS-1:0] CSR_START_X     = 3'd6;
   localparam logic [CSR_BITS-1:0] CSR_START_Y     = 3'd7;

   typedef struct packed {
      logic                 valid;
      logic [SIZE_BITS-1:0] w;
      logic [SIZE_BITS-1:0] h;
      logic [DIM_BITS-1:0]  x;
      logic [DIM_BITS-1:0]  y;
   } box_type;

   // One kept or end-of-scan frame, as classified by the front.
   typedef struct packed {
      logic                 keep;
      logic                 eos;
      box_type              box;
      logic [TIME_BITS-1:0] span_start;
      logic [CNT_BITS-1:0]  votes;
      logic [CNT_BITS-1:0]  kept;
   } record_type;

   typedef struct packed {
      logic                 found;
      logic [SIZE_BITS-1:0] w;
      logic [SIZE_BITS-1:0] h;
      logic [DIM_BITS-1:0]  x;
      logic [DIM_BITS-1:0]  y;
      logic [TIME_BITS-1:0] t;
      logic [CNT_BITS-1:0]  votes;
      logic [CNT_BITS-1:0]  kept;
      logic                 last;
   } result_type;

   function automatic logic equiv(box_type a, box_type b);
      logic [SIZE_BITS-1:0] dw;
      logic [SIZE_BITS-1:0] dh;
      logic [DIM_BITS-1:0]  dx;
      logic [DIM_BITS-1:0]  dy;
      logic                 r;
      dw = (a.w > b.w) ? a.w - b.w : b.w - a.w;
      dh = (a.h > b.h) ? a.h - b.h : b.h - a.h;
      dx = (a.x > b.x) ? a.x - b.x : b.x - a.x;
      dy = (a.y > b.y) ? a.y - b.y : b.y - a.y;
      if (!a.valid && !b.valid) begin
         r = 1'b1;
      end else if (!a.valid || !b.valid) begin
         r = 1'b0;
      end else begin
         r = (dw <= SIZE_TOL) && (dh <= SIZE_TOL) && (dx <= OFFSET_TOL) && (dy <= OFFSET_TOL);
      end
      return r;
   endfunction

endpackage

@@ design/cbs_front.sv @@
// Front: frame sampling, letterbox padding, kept count and run tracking.
module cbs_front import cbs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [STEP_BITS-1:0] cfg_keep_every,
   input  logic                 accept,
   input  logic [DIM_BITS-1:0]  box_width,
   input  logic [DIM_BITS-1:0]  box_height,
   input  logic [DIM_BITS-1:0]  box_left,
   input  logic [DIM_BITS-1:0]  box_top,
   input  logic [TIME_BITS-1:0] frame_time_us,
   input  logic                 end_of_scan,
   output logic                 push,
   output record_type           rec
);

   logic [STEP_BITS-1:0] phase_ff, phase_in;
   logic [CNT_BITS-1:0]  kept_ff, kept_in;
   logic [CNT_BITS-1:0]  votes_ff, votes_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   box_type              run_ff, run_in;

   logic [STEP_BITS-1:0] step;
   logic [STEP_BITS:0]   phase_inc;
   logic                 keep;
   box_type              b;

   always_comb begin
      step      = (cfg_keep_every == '0) ? STEP_BITS'(1) : cfg_keep_every;
      keep      = (phase_ff == '0);
      phase_inc = {1'b0, phase_ff} + (STEP_BITS+1)'(1);

      b.valid = 1'b1;
      b.w     = {1'b0, box_width};
      b.h     = {1'b0, box_height};
      b.x     = box_left;
      b.y     = box_top;
      if (box_left == '0 && box_top != '0) begin
         b.h = b.h + LETTERBOX_PAD;
      end

      phase_in = (phase_inc >= {1'b0, step}) ? '0 : phase_inc[STEP_BITS-1:0];
      kept_in  = kept_ff;
      votes_in = votes_ff;
      start_in = start_ff;
      run_in   = run_ff;
      if (keep) begin
         if (kept_ff != CNT_MAX) begin
            kept_in = kept_ff + CNT_BITS'(1);
         end
         if (equiv(b, run_ff)) begin
            if (votes_ff != CNT_MAX) begin
               votes_in = votes_ff + CNT_BITS'(1);
            end
         end else begin
            run_in   = b;
            start_in = frame_time_us;
            votes_in = CNT_BITS'(1);
         end
      end

      rec.keep       = keep;
      rec.eos        = end_of_scan;
      rec.box        = b;
      rec.span_start = start_in;
      rec.votes      = votes_in;
      rec.kept       = kept_in;
      // Frames that are dropped and do not end the scan have no effect downstream.
      push           = accept && (keep || end_of_scan);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= '0;
         kept_ff  <= '0;
         votes_ff <= '0;
         start_ff <= '0;
         run_ff   <= '0;
      end else if (accept) begin
         if (end_of_scan) begin
            phase_ff <= '0;
            kept_ff  <= '0;
            votes_ff <= '0;
            start_ff <= '0;
            run_ff   <= '0;
         end else begin
            phase_ff <= phase_in;
            kept_ff  <= kept_in;
            votes_ff <= votes_in;
            start_ff <= start_in;
            run_ff   <= run_in;
         end
      end
   end

endmodule

@@ design/cbs_queue.sv @@
// Two-entry record queue between front and back.
module cbs_queue import cbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  record_type push_rec,
   output logic       has_space,
   input  logic       pop,
   output logic       head_valid,
   output record_type head_rec
);

   record_type entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      has_space  = (count_ff != 2'd2);
      head_valid = (count_ff != 2'd0);
      head_rec   = entry_ff[rd_ptr_ff];
      wr_ptr_in  = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in  = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in   = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

@@ design/cbs_back.sv @@
// Back: proposal, one-deep marker hold with revert cancel, scan flush, result queue.
module cbs_back import cbs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [CNT_BITS-1:0]  cfg_vote_floor,
   input  logic [TIME_BITS-1:0] cfg_revert_window,
   input  box_type              cfg_start_box,
   input  logic                 rec_valid,
   input  record_type           rec,
   output logic                 rec_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output result_type           rsp
);

   typedef struct packed {
      logic                 valid;
      box_type              box;
      logic [TIME_BITS-1:0] t;
      logic [CNT_BITS-1:0]  votes;
      logic [CNT_BITS-1:0]  kept;
   } mark_type;

   logic     active_ff, active_in;
   logic     any_ff, any_in;
   box_type  prop_ff, prop_in;
   box_type  prev_ff, prev_in;
   mark_type held_ff, held_in;

   result_type q_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in;
   logic [1:0] rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;

   box_type    prop_cur, prev_cur;
   mark_type   m;
   logic       propose, revert, emit_a, emit_b, rsp_take;
   logic signed [TIME_BITS:0] diff;
   result_type res_a, res_b, res0, res1;
   logic [1:0] n_res;

   function automatic result_type to_result(mark_type mk, logic last);
      result_type r;
      r.found = 1'b1;
      r.w     = mk.box.w;
      r.h     = mk.box.h;
      r.x     = mk.box.x;
      r.y     = mk.box.y;
      r.t     = mk.t;
      r.votes = mk.votes;
      r.kept  = mk.kept;
      r.last  = last;
      return r;
   endfunction

   always_comb begin
      // Take a record only when two result slots are free.
      rec_pop  = rec_valid && (count_ff <= 3'd2);
      rsp_valid = (count_ff != 3'd0);
      rsp       = q_ff[rd_ptr_ff];
      rsp_take  = rsp_valid && rsp_ready;

      prop_cur = active_ff ? prop_ff : cfg_start_box;
      prev_cur = active_ff ? prev_ff : cfg_start_box;

      m.valid = 1'b1;
      m.box   = rec.box;
      m.t     = rec.span_start;
      m.votes = rec.votes;
      m.kept  = rec.kept;

      diff    = $signed({1'b0, rec.span_start}) - $signed({1'b0, held_ff.t});
      propose = rec.keep && (rec.votes >= cfg_vote_floor) && !equiv(rec.box, prop_cur);
      revert  = equiv(rec.box, prev_cur) && (diff < $signed({1'b0, cfg_revert_window}));

      active_in = 1'b1;
      any_in    = any_ff;
      prop_in   = prop_cur;
      prev_in   = prev_cur;
      held_in   = held_ff;
      emit_a    = 1'b0;
      emit_b    = 1'b0;
      res_a     = to_result(held_ff, 1'b0);

      if (propose) begin
         prop_in = rec.box;
         if (!held_ff.valid) begin
            held_in = m;
         end else if (revert) begin
            // Drop the held marker together with this one.
            held_in = '0;
         end else begin
            emit_a  = 1'b1;
            any_in  = 1'b1;
            prev_in = held_ff.box;
            held_in = m;
         end
      end

      res_b = to_result(held_in, 1'b1);
      if (rec.eos) begin
         if (held_in.valid) begin
            emit_b = 1'b1;
         end else if (!any_in) begin
            emit_b = 1'b1;
            res_b  = '0;
            res_b.last = 1'b1;
         end
         active_in = 1'b0;
         any_in    = 1'b0;
         held_in   = '0;
      end

      res0  = emit_a ? res_a : res_b;
      res1  = res_b;
      n_res = 2'(emit_a) + 2'(emit_b);
      if (!rec_pop) begin
         n_res = 2'd0;
      end

      wr_ptr_in = wr_ptr_ff + n_res;
      rd_ptr_in = rd_ptr_ff + 2'(rsp_take);
      count_in  = count_ff + 3'(n_res) - 3'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         any_ff    <= 1'b0;
         held_ff   <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (rec_pop) begin
            active_ff <= active_in;
            any_ff    <= any_in;
            held_ff   <= held_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_pop) begin
         prop_ff <= prop_in;
         prev_ff <= prev_in;
      end
      if (n_res != 2'd0) begin
         q_ff[wr_ptr_ff] <= res0;
      end
      if (n_res == 2'd2) begin
         q_ff[wr_ptr_ff + 2'd1] <= res1;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'd4)
      else $error("result queue count out of range");

   a_found_zero_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp.found |-> rsp.last)
      else $error("found-zero result not marked last");

   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      rec_pop && rec.eos |=> !held_ff.valid && !active_ff && !any_ff)
      else $error("scan end did not clear back state");

   a_held_active: assert property (@(posedge clock) disable iff (reset)
      held_ff.valid |-> active_ff)
      else $error("marker held outside a scan");
`endif

endmodule

@@ design/crop_box_stabilizer.sv @@
// Top level: configuration registers, front, record queue and back.
//
//   channel   direction  handshake                   payload
//   req_      in         req_valid / req_ready       box, frame time, end of scan
//   rsp_      out        rsp_valid / rsp_ready       marker fields, found, last
//   csr_      in         csr_write_en                csr_index, csr_wdata
//
// One frame is taken per cycle while req_ready is high. Records are registered in the
// record queue, results in the result queue; an end-of-scan frame can give two results.
// The back takes a record only when two of its four result slots are free;
// req_ready drops when the two-entry record queue is full.
// Synchronous reset clears all control state; no clearing pass follows it.
module crop_box_stabilizer import cbs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [DIM_BITS-1:0]  req_box_width,
   input  logic [DIM_BITS-1:0]  req_box_height,
   input  logic [DIM_BITS-1:0]  req_box_left,
   input  logic [DIM_BITS-1:0]  req_box_top,
   input  logic [TIME_BITS-1:0] req_frame_time_us,
   input  logic                 req_end_of_scan,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic                 rsp_found,
   output logic [SIZE_BITS-1:0] rsp_out_width,
   output logic [SIZE_BITS-1:0] rsp_out_height,
   output logic [DIM_BITS-1:0]  rsp_out_left,
   output logic [DIM_BITS-1:0]  rsp_out_top,
   output logic [TIME_BITS-1:0] rsp_run_start_us,
   output logic [CNT_BITS-1:0]  rsp_vote_count,
   output logic [CNT_BITS-1:0]  rsp_sampled_count,
   output logic                 rsp_last_of_scan,
   input  logic                 csr_write_en,
   input  logic [CSR_BITS-1:0]  csr_index,
   input  logic [DATA_BITS-1:0] csr_wdata
);

   logic [CNT_BITS-1:0]  vote_floor_ff;
   logic [STEP_BITS-1:0] keep_every_ff;
   logic [TIME_BITS-1:0] revert_win_ff;
   box_type              start_box_ff;

   logic       accept, push, has_space, head_valid, pop;
   record_type push_rec, head_rec;
   result_type rsp;

   assign req_ready = has_space;
   assign accept    = req_valid && has_space;

   always_ff @(posedge clock) begin
      if (reset) begin
         vote_floor_ff  <= CNT_BITS'(2);
         keep_every_ff  <= STEP_BITS'(1);
         revert_win_ff  <= TIME_BITS'(100000);
         start_box_ff   <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_VOTE_FLOOR:  vote_floor_ff      <= csr_wdata[CNT_BITS-1:0];
            CSR_KEEP_EVERY:  keep_every_ff      <= csr_wdata[STEP_BITS-1:0];
            CSR_REVERT_WIN:  revert_win_ff      <= csr_wdata[TIME_BITS-1:0];
            CSR_START_VALID: start_box_ff.valid <= csr_wdata[0];
            CSR_START_W:     start_box_ff.w     <= csr_wdata[SIZE_BITS-1:0];
            CSR_START_H:     start_box_ff.h     <= csr_wdata[SIZE_BITS-1:0];
            CSR_START_X:     start_box_ff.x     <= csr_wdata[DIM_BITS-1:0];
            CSR_START_Y:     start_box_ff.y     <= csr_wdata[DIM_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   cbs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg_keep_every  (keep_every_ff),
      .accept          (accept),
      .box_width       (req_box_width),
      .box_height      (req_box_height),
      .box_left        (req_box_left),
      .box_top         (req_box_top),
      .frame_time_us   (req_frame_time_us),
      .end_of_scan     (req_end_of_scan),
      .push            (push),
      .rec             (push_rec)
   );

   cbs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_rec   (push_rec),
      .has_space  (has_space),
      .pop        (pop),
      .head_valid (head_valid),
      .head_rec   (head_rec)
   );

   cbs_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg_vote_floor    (vote_floor_ff),
      .cfg_revert_window (revert_win_ff),
      .cfg_start_box     (start_box_ff),
      .rec_valid         (head_valid),
      .rec               (head_rec),
      .rec_pop           (pop),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp               (rsp)
   );

   assign rsp_found         = rsp.found;
   assign rsp_out_width     = rsp.w;
   assign rsp_out_height    = rsp.h;
   assign rsp_out_left      = rsp.x;
   assign rsp_out_top       = rsp.y;
   assign rsp_run_start_us  = rsp.t;
   assign rsp_vote_count    = rsp.votes;
   assign rsp_sampled_count = rsp.kept;
   assign rsp_last_of_scan  = rsp.last;

endmodule

@@ test/tb_crop_box_stabilizer.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for crop_box_stabilizer: predicts crop markers per frame and checks results.
import cbs_pkg::*;

class marker_ledger;
   bit [15:0]  vote_floor;
   bit [11:0]  keep_every;
   bit [31:0]  revert_window;
   bit         start_valid;
   bit [13:0]  start_w;
   bit [13:0]  start_h;
   bit [12:0]  start_x;
   bit [12:0]  start_y;

   bit [11:0]  frame_phase;
   bit [15:0]  kept_frames;
   bit [15:0]  streak_votes;
   bit [31:0]  streak_start;
   box_type    run_box;
   box_type    proposed;
   box_type    previous;
   box_type    held_box;
   bit [31:0]  held_start;
   bit [15:0]  held_votes;
   bit [15:0]  held_kept;
   bit         held_valid;
   bit         any_out;
   bit         in_scan;

   result_type due_markers[$];
   int         mismatches;

   function new();
      vote_floor    = 16'd2;
      keep_every    = 12'd1;
      revert_window = 32'd100000;
      start_valid   = 1'b0;
      start_w       = '0;
      start_h       = '0;
      start_x       = '0;
      start_y       = '0;
      mismatches    = 0;
      clear_scan();
   endfunction

   function void clear_scan();
      frame_phase  = '0;
      kept_frames  = '0;
      streak_votes = '0;
      streak_start = '0;
      run_box      = '0;
      proposed     = '0;
      previous     = '0;
      held_box     = '0;
      held_start   = '0;
      held_votes   = '0;
      held_kept    = '0;
      held_valid   = 1'b0;
      any_out      = 1'b0;
      in_scan      = 1'b0;
   endfunction

   function void set_reg(logic [CSR_BITS-1:0] idx, logic [DATA_BITS-1:0] data);
      case (idx)
         CSR_VOTE_FLOOR:  vote_floor    = data[15:0];
         CSR_KEEP_EVERY:  keep_every    = data[11:0];
         CSR_REVERT_WIN:  revert_window = data;
         CSR_START_VALID: start_valid   = data[0];
         CSR_START_W:     start_w       = data[13:0];
         CSR_START_H:     start_h       = data[13:0];
         CSR_START_X:     start_x       = data[12:0];
         CSR_START_Y:     start_y       = data[12:0];
         default: ;
      endcase
   endfunction

   function int spread(int a, int b);
      return (a > b) ? a - b : b - a;
   endfunction

   function bit near(box_type a, box_type b);
      if (!a.valid && !b.valid) return 1'b1;
      if (!a.valid || !b.valid) return 1'b0;
      return spread(a.w, b.w) <= SIZE_TOL && spread(a.h, b.h) <= SIZE_TOL &&
             spread(a.x, b.x) <= OFFSET_TOL && spread(a.y, b.y) <= OFFSET_TOL;
   endfunction

   function void emit(bit found, bit last);
      result_type r;
      r = '0;
      r.found = found;
      if (found) begin
         r.w     = held_box.w;
         r.h     = held_box.h;
         r.x     = held_box.x;
         r.y     = held_box.y;
         r.t     = held_start;
         r.votes = held_votes;
         r.kept  = held_kept;
      end
      r.last = last;
      due_markers.insert(due_markers.size(), r);
   endfunction

   function void hold_current(box_type b);
      held_box   = b;
      held_start = streak_start;
      held_votes = streak_votes;
      held_kept  = kept_frames;
      held_valid = 1'b1;
   endfunction

   function void take_frame(logic [12:0] w, logic [12:0] h, logic [12:0] x, logic [12:0] y,
                            logic [31:0] t, logic eos);
      box_type b;
      box_type s;
      bit      take;
      int      step;
      longint  lag;
      step = (keep_every == 0) ? 1 : int'(keep_every);
      // start crop is latched on the first frame of each scan
      if (!in_scan) begin
         s.valid  = start_valid;
         s.w      = start_w;
         s.h      = start_h;
         s.x      = start_x;
         s.y      = start_y;
         proposed = s;
         previous = s;
         in_scan  = 1'b1;
      end
      take = (frame_phase == 0);
      frame_phase = (int'(frame_phase) + 1 >= step) ? '0 : frame_phase + 12'd1;
      if (take) begin
         b.valid = 1'b1;
         b.w     = {1'b0, w};
         b.h     = {1'b0, h};
         b.x     = x;
         b.y     = y;
         if (x == 0 && y != 0) b.h = b.h + LETTERBOX_PAD;
         if (kept_frames != 16'hFFFF) kept_frames++;
         if (near(b, run_box)) begin
            if (streak_votes != 16'hFFFF) streak_votes++;
         end else begin
            run_box      = b;
            streak_start = t;
            streak_votes = 16'd1;
         end
         if (streak_votes >= vote_floor && !near(b, proposed)) begin
            proposed = b;
            if (!held_valid) begin
               hold_current(b);
            end else begin
               lag = $signed({32'd0, streak_start}) - $signed({32'd0, held_start});
               if (near(b, previous) && lag < $signed({32'd0, revert_window})) begin
                  // quick revert: drop the held marker and this one
                  held_box   = '0;
                  held_start = '0;
                  held_votes = '0;
                  held_kept  = '0;
                  held_valid = 1'b0;
               end else begin
                  emit(1'b1, 1'b0);
                  any_out  = 1'b1;
                  previous = held_box;
                  hold_current(b);
               end
            end
         end
      end
      if (eos) begin
         if (held_valid) emit(1'b1, 1'b1);
         else if (!any_out) emit(1'b0, 1'b1);
         clear_scan();
      end
   endfunction

   function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         if (mismatches < 40)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatches++;
      end
   endfunction

   function void check_marker(result_type got);
      result_type want;
      if (due_markers.size() == 0) begin
         if (mismatches < 40)
            $display("%0t: unexpected result, expected none, actual found=%0d w=%0d h=%0d last=%0d",
                     $time, got.found, got.w, got.h, got.last);
         mismatches++;
         return;
      end
      want = due_markers.pop_front();
      compare("found", want.found, got.found);
      compare("out_width", want.w, got.w);
      compare("out_height", want.h, got.h);
      compare("out_left", want.x, got.x);
      compare("out_top", want.y, got.y);
      compare("run_start_us", want.t, got.t);
      compare("vote_count", want.votes, got.votes);
      compare("sampled_count", want.kept, got.kept);
      compare("last_of_scan", want.last, got.last);
   endfunction
endclass

module tb_crop_box_stabilizer;
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [DIM_BITS-1:0]  req_box_width = '0;
   logic [DIM_BITS-1:0]  req_box_height = '0;
   logic [DIM_BITS-1:0]  req_box_left = '0;
   logic [DIM_BITS-1:0]  req_box_top = '0;
   logic [TIME_BITS-1:0] req_frame_time_us = '0;
   logic                 req_end_of_scan = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_found;
   logic [SIZE_BITS-1:0] rsp_out_width;
   logic [SIZE_BITS-1:0] rsp_out_height;
   logic [DIM_BITS-1:0]  rsp_out_left;
   logic [DIM_BITS-1:0]  rsp_out_top;
   logic [TIME_BITS-1:0] rsp_run_start_us;
   logic [CNT_BITS-1:0]  rsp_vote_count;
   logic [CNT_BITS-1:0]  rsp_sampled_count;
   logic                 rsp_last_of_scan;
   logic                 csr_write_en = 1'b0;
   logic [CSR_BITS-1:0]  csr_index = '0;
   logic [DATA_BITS-1:0] csr_wdata = '0;

   marker_ledger ledger = new();

   bit         pace_on = 1'b1;
   int         burst_left = 0;
   bit         hold_off_req = 1'b0;
   int         hold_left = 0;
   int         pat_left = 0;
   logic [4:0] pat_pos = '0;
   logic [31:0] stall_pat = '0;
   result_type seen;

   crop_box_stabilizer u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_box_width     (req_box_width),
      .req_box_height    (req_box_height),
      .req_box_left      (req_box_left),
      .req_box_top       (req_box_top),
      .req_frame_time_us (req_frame_time_us),
      .req_end_of_scan   (req_end_of_scan),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_found         (rsp_found),
      .rsp_out_width     (rsp_out_width),
      .rsp_out_height    (rsp_out_height),
      .rsp_out_left      (rsp_out_left),
      .rsp_out_top       (rsp_out_top),
      .rsp_run_start_us  (rsp_run_start_us),
      .rsp_vote_count    (rsp_vote_count),
      .rsp_sampled_count (rsp_sampled_count),
      .rsp_last_of_scan  (rsp_last_of_scan),
      .csr_write_en      (csr_write_en),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #5 clock = ~clock;

   // result side: check each transfer, stall on a rotating random pattern or during a long hold-off
   always @(posedge clock) begin
      if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         seen.found = rsp_found;
         seen.w     = rsp_out_width;
         seen.h     = rsp_out_height;
         seen.x     = rsp_out_left;
         seen.y     = rsp_out_top;
         seen.t     = rsp_run_start_us;
         seen.votes = rsp_vote_count;
         seen.kept  = rsp_sampled_count;
         seen.last  = rsp_last_of_scan;
         ledger.check_marker(seen);
      end
      if (hold_off_req) begin
         hold_off_req = 1'b0;
         hold_left    = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         if (pat_left == 0) begin
            pat_left = $urandom_range(20, 90);
            case ($urandom_range(0, 3))
               0: stall_pat = '0;
               1: stall_pat = $urandom();
               default: stall_pat = $urandom() & $urandom();
            endcase
         end
         pat_left--;
         pat_pos = pat_pos + 5'd1;
         rsp_ready <= !stall_pat[pat_pos];
      end
   end

   function automatic logic [12:0] pick_dim();
      case ($urandom_range(0, 9))
         0: return 13'd0;
         1: return 13'h1FFF;
         2: return 13'($urandom_range(0, 12));
         3: return 13'($urandom_range(8180, 8191));
         default: return 13'($urandom_range(0, 8191));
      endcase
   endfunction

   function automatic logic [12:0] jitter(logic [12:0] v, int r);
      int n;
      n = int'(v) + int'($urandom_range(0, 2 * r)) - r;
      if (n < 0) n = 0;
      if (n > 8191) n = 8191;
      return 13'(n);
   endfunction

   function automatic logic [31:0] time_step();
      case ($urandom_range(0, 9))
         0: return $urandom();
         1: return 32'd0 - 32'($urandom_range(1, 60000));
         2, 3: return 32'($urandom_range(40000, 150000));
         default: return 32'($urandom_range(0, 20000));
      endcase
   endfunction

   task automatic send_frame(input logic [12:0] w, input logic [12:0] h, input logic [12:0] x,
                             input logic [12:0] y, input logic [31:0] t, input logic eos);
      int gap;
      gap = 0;
      if (pace_on) begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 9);
         end
         burst_left--;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_box_width     <= w;
      req_box_height    <= h;
      req_box_left      <= x;
      req_box_top       <= y;
      req_frame_time_us <= t;
      req_end_of_scan   <= eos;
      do @(posedge clock); while (req_ready !== 1'b1);
      ledger.take_frame(w, h, x, y, t, eos);
   endtask

   // hold input off until every expected result is out, then let the back go idle
   task automatic settle();
      req_valid <= 1'b0;
      while (ledger.due_markers.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic program_regs(input logic [15:0] votes_min, input logic [11:0] step,
                               input logic [31:0] window, input logic sc_valid,
                               input logic [13:0] sc_w, input logic [13:0] sc_h,
                               input logic [12:0] sc_x, input logic [12:0] sc_y);
      logic [DATA_BITS-1:0] vals [8];
      vals[CSR_VOTE_FLOOR]  = 32'(votes_min);
      vals[CSR_KEEP_EVERY]  = 32'(step);
      vals[CSR_REVERT_WIN]  = window;
      vals[CSR_START_VALID] = 32'(sc_valid);
      vals[CSR_START_W]     = 32'(sc_w);
      vals[CSR_START_H]     = 32'(sc_h);
      vals[CSR_START_X]     = 32'(sc_x);
      vals[CSR_START_Y]     = 32'(sc_y);
      for (int i = 0; i < 8; i++) begin
         csr_write_en <= 1'b1;
         csr_index    <= CSR_BITS'(i);
         csr_wdata    <= vals[i];
         @(posedge clock);
         ledger.set_reg(CSR_BITS'(i), vals[i]);
      end
      csr_write_en <= 1'b0;
   endtask

   // scans made of runs of jittered boxes, with frequent switches back to the prior box
   task automatic random_scans(input int budget, input int stretch);
      logic [12:0] mw [4];
      logic [12:0] mh [4];
      logic [12:0] mx [4];
      logic [12:0] my [4];
      logic [31:0] t;
      int sent;
      int modes;
      int len;
      int cur;
      int prior;
      int nxt;
      int run_left;
      sent = 0;
      while (sent < budget) begin
         modes = $urandom_range(1, 4);
         for (int k = 0; k < 4; k++) begin
            mw[k] = pick_dim();
            mh[k] = pick_dim();
            if ($urandom_range(0, 2) == 0) begin
               mx[k] = 13'd0;
               my[k] = 13'($urandom_range(1, 400));
            end else begin
               mx[k] = pick_dim();
               my[k] = pick_dim();
            end
         end
         t        = ($urandom_range(0, 4) == 0) ? $urandom() : 32'($urandom_range(0, 1000));
         len      = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 48);
         cur      = 0;
         prior    = 0;
         run_left = stretch * $urandom_range(1, 6);
         for (int i = 0; i < len; i++) begin
            if (run_left == 0) begin
               nxt      = ($urandom_range(0, 1) == 1) ? prior : $urandom_range(0, modes - 1);
               prior    = cur;
               cur      = nxt;
               run_left = stretch * (($urandom_range(0, 3) == 0) ? $urandom_range(1, 2)
                                                                   : $urandom_range(2, 10));
            end
            run_left--;
            t = t + time_step();
            if ($urandom_range(0, 11) == 0)
               send_frame(13'($urandom()), 13'($urandom()), 13'($urandom()), 13'($urandom()),
                          $urandom(), i == len - 1);
            else
               send_frame(jitter(mw[cur], 4), jitter(mh[cur], 4), jitter(mx[cur], 2),
                          jitter(my[cur], 2), t, i == len - 1);
            sent++;
         end
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      program_regs(16'd2, 12'd1, 32'd100000, 1'b0, 14'd0, 14'd0, 13'd0, 13'd0);
      // lone end-of-scan frame at full scale: no stable crop
      send_frame(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 32'hFFFF_FFFF, 1'b1);
      // letterboxed box at zero width and full height
      send_frame(13'd0, 13'h1FFF, 13'd0, 13'd1, 32'd10, 1'b0);
      send_frame(13'd0, 13'h1FFF, 13'd0, 13'd1, 32'd20, 1'b0);
      send_frame(13'd0, 13'h1FFF, 13'd0, 13'h1FFF, 32'd30, 1'b1);
      // quick revert cancels the held marker and the new one, so only the first marker comes out
      send_frame(13'd1920, 13'd800, 13'd0, 13'd140, 32'd0, 1'b0);
      send_frame(13'd1920, 13'd800, 13'd0, 13'd140, 32'd1000, 1'b0);
      send_frame(13'd1920, 13'd1080, 13'd0, 13'd0, 32'd2000, 1'b0);
      send_frame(13'd1920, 13'd1080, 13'd0, 13'd0, 32'd3000, 1'b0);
      send_frame(13'd1920, 13'd800, 13'd0, 13'd140, 32'd4000, 1'b0);
      send_frame(13'd1920, 13'd800, 13'd0, 13'd140, 32'd5000, 1'b0);
      send_frame(13'd1920, 13'd800, 13'd0, 13'd140, 32'd6000, 1'b1);
      // revert with time running backward, then a fresh crop flushed at scan end
      send_frame(13'd1280, 13'd720, 13'd40, 13'd0, 32'd50000, 1'b0);
      send_frame(13'd1280, 13'd720, 13'd40, 13'd0, 32'd51000, 1'b0);
      send_frame(13'd640, 13'd480, 13'd8, 13'd8, 32'd60000, 1'b0);
      send_frame(13'd640, 13'd480, 13'd8, 13'd8, 32'd61000, 1'b0);
      send_frame(13'd1280, 13'd720, 13'd40, 13'd0, 32'd10000, 1'b0);
      send_frame(13'd1280, 13'd720, 13'd40, 13'd0, 32'd11000, 1'b0);
      send_frame(13'd100, 13'd50, 13'd3000, 13'd3000, 32'd400000, 1'b0);
      send_frame(13'd100, 13'd50, 13'd3000, 13'd3000, 32'd401000, 1'b1);
      settle();

      // zero votes and zero step; boxes near the applied crop give no marker
      program_regs(16'd0, 12'd0, 32'd100000, 1'b1, 14'd1920, 14'd1080, 13'd0, 13'd0);
      send_frame(13'd1922, 13'd1080, 13'd0, 13'd0, 32'd0, 1'b0);
      send_frame(13'd1920, 13'd1080, 13'd2, 13'd0, 32'd100, 1'b1);
      send_frame(13'd1280, 13'd720, 13'd0, 13'd0, 32'd5, 1'b0);
      send_frame(13'd1280, 13'd720, 13'd0, 13'd0, 32'd6, 1'b1);
      settle();

      program_regs(16'd2, 12'd1, 32'd100000, 1'b0, 14'($urandom_range(0, 8193)),
                   14'($urandom_range(0, 8193)), 13'($urandom()), 13'($urandom()));
      random_scans(120, 1);
      settle();

      // long receiver hold-off while frames keep coming
      program_regs(16'd1, 12'd2, 32'd0, 1'b1, 14'd8193, 14'd8193, 13'd8191, 13'd8191);
      hold_off_req = 1'b1;
      random_scans(110, 2);
      settle();

      program_regs(16'd3, 12'd3, 32'hFFFF_FFFF, 1'b1, 14'($urandom_range(0, 8193)),
                   14'($urandom_range(0, 8193)), 13'($urandom()), 13'($urandom()));
      random_scans(100, 3);
      settle();

      program_regs(16'hFFFF, 12'hFFF, 32'd100000, 1'b0, 14'd0, 14'd0, 13'd0, 13'd0);
      random_scans(40, 1);
      settle();

      program_regs(16'd0, 12'd0, 32'd50000, 1'b0, 14'd0, 14'd0, 13'd0, 13'd0);
      random_scans(80, 1);
      settle();

      // one steady back-to-back run with boxes at each edge of the size tolerance
      program_regs(16'd2, 12'd1, 32'd100000, 1'b0, 14'd0, 14'd0, 13'd0, 13'd0);
      pace_on = 1'b0;
      send_frame(13'd100, 13'd100, 13'd100, 13'd100, 32'd0, 1'b0);
      send_frame(13'd92, 13'd100, 13'd100, 13'd100, 32'd10, 1'b0);
      for (int i = 2; i < 14; i++)
         send_frame(13'd100, 13'd100, 13'd100, 13'd100, 32'(i * 10), 1'b0);
      send_frame(13'd108, 13'd100, 13'd100, 13'd100, 32'd700000, 1'b0);
      send_frame(13'd100, 13'd100, 13'd100, 13'd100, 32'd700010, 1'b1);
      pace_on = 1'b1;
      settle();

      program_regs(16'd2, 12'd1, 32'd30000, 1'b1, 14'($urandom_range(0, 8193)),
                   14'($urandom_range(0, 8193)), 13'($urandom()), 13'($urandom()));
      random_scans(50, 1);
      settle();
      repeat (20) @(posedge clock);

      if (ledger.mismatches == 0 && ledger.due_markers.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
